// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

	localparam int NumSlotsDefault = 64;

	typedef enum logic [2:0] {
		MODE_TICK      = 3'd0,
		MODE_SET_STATE = 3'd1,
		MODE_SELECT    = 3'd2,
		MODE_RUN_END   = 3'd3,
		MODE_SET_PRIO  = 3'd4
	} mode_t;

	localparam logic [2:0] ST_UNUSED   = 3'd0;
	localparam logic [2:0] ST_USED     = 3'd1;
	localparam logic [2:0] ST_SLEEPING = 3'd2;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;
	localparam logic [2:0] ST_RUNNING  = 3'd4;
	localparam logic [2:0] ST_MAX      = 3'd5;

	localparam logic [6:0] PRIO_DEFAULT = 7'd60;
	localparam logic [3:0] NICE_DEFAULT = 4'd5;
	localparam logic [7:0] PRIO_LIMIT   = 8'd100;

	typedef struct packed {
		logic [2:0] mode;
		logic [5:0] slot;
		logic [2:0] new_state;
		logic [7:0] req_prio;
	} sched_req_t;

	typedef struct packed {
		logic       status;
		logic [5:0] chosen_slot;
		logic [6:0] prev_prio;
		logic       should_yield;
	} sched_resp_t;

	// One table entry, held in a single memory word.
	typedef struct packed {
		logic [2:0]  state;
		logic [6:0]  sprio;
		logic [3:0]  nice;
		logic [31:0] sched;
		logic [31:0] created;
		logic [31:0] run;
		logic [31:0] sleep;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_LAST,
		S_SEL_RD,
		S_SEL_WR,
		S_ONE_RD,
		S_ONE_WR,
		S_DIV,
		S_DIV_WR,
		S_CLEAR,
		S_DONE
	} fsm_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic [6:0] dyn_prio(input logic [6:0] sp, input logic [3:0] nc);
		logic signed [9:0] p;
		p = $signed({3'b000, sp}) - $signed({6'b0, nc}) + 10'sd5;
		if (p > 10'sd100) return 7'd100;
		if (p < 10'sd0) return 7'd0;
		return p[6:0];
	endfunction

endpackage

// ===== rtl/core/pps_stream_if.sv =====
interface pps_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pps_divider.sv =====
// Restoring divider for 10 * sleep / (run + sleep); quotient is 0..10, one bit a cycle.
module pps_divider import pps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] run,
	input  logic [31:0] sleep,
	output logic        busy,
	output logic [3:0]  quot
);
	logic [35:0] num_q;
	logic [32:0] den_q;
	logic [36:0] rem_q;
	logic [5:0]  cnt_q;
	logic [36:0] trial;

	assign trial = {rem_q[35:0], num_q[35]} - {4'b0, den_q};
	assign busy = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd36;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {sleep, 3'b000} + {3'b000, sleep, 1'b0};
			den_q <= {1'b0, run} + {1'b0, sleep};
			rem_q <= '0;
			quot  <= '0;
		end else if (busy) begin
			num_q <= {num_q[34:0], 1'b0};
			if (!trial[36]) begin
				rem_q <= trial;
				quot  <= {quot[2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[35:0], num_q[35]};
				quot  <= {quot[2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/priority_process_selector.sv =====
// Tick and select sweep the whole table; select then writes the chosen entry back unless no
// slot is runnable, and run_end also runs the divider unless no ticks are recorded for the
// slot. A rejected item goes straight to the result.
// Throughput: one item at a time, the next accepted once the result has been taken; the table
// memory, swept one entry a cycle for tick and select, sets the rate. After reset a clearing
// pass writes every entry before the first item is accepted.
module priority_process_selector import pps_pkg::*; #(
	parameter int NUM_SLOTS = NumSlotsDefault
) (
	input  logic clk,
	input  logic arst_n,
	pps_stream_if.sink   in_ch,
	pps_stream_if.source out_ch
);
	localparam int AW = $clog2(NUM_SLOTS);

	entry_t mem [NUM_SLOTS];
	entry_t rd_data;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t        wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	fsm_t state_q, state_d;
	logic [2:0]    mode_q, nst_q;
	logic [7:0]    npri_q;
	logic [AW-1:0] slot_q, idx_q;
	logic [AW-1:0] pend_q;
	logic          pend_v_q;
	logic [31:0]   tick_q;
	logic          found_q;
	logic [AW-1:0] best_q;
	logic [6:0]    bestp_q;
	logic [31:0]   bsched_q, bcreate_q;
	logic          status_q, yield_q;
	logic [5:0]    chosen_q;
	logic [6:0]    oldp_q;
	logic          out_v_q;
	entry_t        ent_q;

	logic       div_start, div_busy;
	logic [3:0] div_quot;

	pps_divider u_div (
		.clk, .arst_n, .start(div_start), .run(rd_data.run), .sleep(rd_data.sleep),
		.busy(div_busy), .quot(div_quot)
	);

	logic accept, bad_in;
	logic [5:0] in_slot;
	assign in_slot = in_ch.payload.slot;
	assign in_ch.ready = (state_q == S_IDLE) && !out_v_q;
	assign accept = in_ch.valid && in_ch.ready;
	always_comb begin
		bad_in = 1'b0;
		if (in_ch.payload.mode inside {MODE_SET_STATE, MODE_RUN_END, MODE_SET_PRIO}) begin
			if ({26'd0, in_slot} >= 32'(NUM_SLOTS)) bad_in = 1'b1;
			else if (in_ch.payload.mode != MODE_SET_PRIO && in_ch.payload.new_state > ST_MAX)
				bad_in = 1'b1;
			else if (in_ch.payload.mode == MODE_SET_PRIO && in_ch.payload.req_prio > PRIO_LIMIT)
				bad_in = 1'b1;
		end else if (in_ch.payload.mode > MODE_SET_PRIO) begin
			bad_in = 1'b1;
		end
	end

	// Scan pipeline: the entry for idx_q - 1 arrives in rd_data while idx_q is read.
	logic [AW-1:0] prev_idx;
	logic          last_idx;
	logic [6:0]    cur_p;
	logic          better;
	entry_t        tick_wr;
	assign prev_idx = idx_q - AW'(1);
	assign last_idx = {{(32-AW){1'b0}}, idx_q} == 32'(NUM_SLOTS - 1);
	assign cur_p = dyn_prio(rd_data.sprio, rd_data.nice);
	assign better = (rd_data.state == ST_RUNNABLE) && (!found_q || cur_p < bestp_q ||
		(cur_p == bestp_q && (rd_data.sched > bsched_q ||
		(rd_data.sched == bsched_q && rd_data.created < bcreate_q))));
	always_comb begin
		tick_wr = rd_data;
		if (rd_data.state == ST_RUNNING) tick_wr.run = sat_inc(rd_data.run);
		else if (rd_data.state == ST_SLEEPING) tick_wr.sleep = sat_inc(rd_data.sleep);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (last_idx) state_d = S_IDLE;
			S_IDLE: if (accept) begin
				if (bad_in) state_d = S_DONE;
				else if (in_ch.payload.mode == MODE_TICK || in_ch.payload.mode == MODE_SELECT)
					state_d = S_SCAN;
				else state_d = S_ONE_RD;
			end
			S_SCAN: if (last_idx) state_d = S_SCAN_LAST;
			S_SCAN_LAST: state_d = (mode_q == MODE_SELECT) ? S_SEL_RD : S_DONE;
			S_SEL_RD: state_d = found_q ? S_SEL_WR : S_DONE;
			S_SEL_WR: state_d = S_DONE;
			S_ONE_RD: state_d = S_ONE_WR;
			S_ONE_WR: state_d = (mode_q == MODE_RUN_END &&
				(rd_data.run != '0 || rd_data.sleep != '0)) ? S_DIV : S_DONE;
			S_DIV: if (!div_busy && !div_start) state_d = S_DIV_WR;
			S_DIV_WR: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0; rd_addr = idx_q; wr_en = 1'b0; wr_addr = prev_idx; wr_data = '0;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1; wr_addr = idx_q;
			end
			S_SCAN: begin
				rd_en = 1'b1;
				if (pend_v_q && mode_q == MODE_TICK) begin
					wr_en = 1'b1; wr_addr = pend_q; wr_data = tick_wr;
				end
			end
			S_SCAN_LAST: if (mode_q == MODE_TICK) begin
				wr_en = 1'b1; wr_addr = pend_q; wr_data = tick_wr;
			end
			S_SEL_RD: begin
				rd_en = found_q; rd_addr = best_q;
			end
			S_SEL_WR: begin
				wr_en = 1'b1; wr_addr = best_q; wr_data = rd_data;
				wr_data.state = ST_RUNNING; wr_data.sched = sat_inc(rd_data.sched);
			end
			S_ONE_RD: begin
				rd_en = 1'b1; rd_addr = slot_q;
			end
			S_ONE_WR: begin
				wr_en = 1'b1; wr_addr = slot_q; wr_data = rd_data;
				case (mode_q)
					MODE_SET_STATE: begin
						if (nst_q == ST_UNUSED) wr_data = '0;
						else if (rd_data.state == ST_UNUSED) begin
							wr_data = '0; wr_data.sprio = PRIO_DEFAULT;
							wr_data.nice = NICE_DEFAULT; wr_data.created = tick_q;
						end
						if (nst_q != ST_UNUSED) wr_data.state = nst_q;
					end
					MODE_RUN_END: begin
						wr_data.state = nst_q;
						div_start = 1'b1;
					end
					MODE_SET_PRIO: begin
						wr_data.sprio = npri_q[6:0]; wr_data.nice = NICE_DEFAULT;
						wr_data.run = '0; wr_data.sleep = '0;
					end
					default: wr_en = 1'b0;
				endcase
			end
			S_DIV_WR: begin
				wr_en = 1'b1; wr_addr = slot_q; wr_data = ent_q; wr_data.nice = div_quot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; idx_q <= '0; tick_q <= '0; out_v_q <= 1'b0;
			pend_v_q <= 1'b0; found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				S_CLEAR: idx_q <= idx_q + AW'(1);
				S_IDLE: begin
					idx_q <= '0; pend_v_q <= 1'b0; found_q <= 1'b0;
				end
				S_SCAN: begin
					idx_q <= idx_q + AW'(1); pend_v_q <= 1'b1;
					if (pend_v_q && better) found_q <= 1'b1;
				end
				S_SCAN_LAST: begin
					if (better) found_q <= 1'b1;
					if (mode_q == MODE_TICK) tick_q <= sat_inc(tick_q);
				end
				S_DONE: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= in_ch.payload.mode; nst_q <= in_ch.payload.new_state;
			npri_q <= in_ch.payload.req_prio; slot_q <= AW'(in_slot);
			status_q <= bad_in; yield_q <= 1'b0; chosen_q <= '0; oldp_q <= '0;
		end
		if (state_q == S_SCAN) pend_q <= idx_q;
		if ((state_q == S_SCAN && pend_v_q) || state_q == S_SCAN_LAST) begin
			if (better) begin
				best_q <= pend_q; bestp_q <= cur_p;
				bsched_q <= rd_data.sched; bcreate_q <= rd_data.created;
			end
		end
		if (state_q == S_SEL_RD) begin
			if (found_q) chosen_q <= 6'(best_q);
			else status_q <= 1'b1;
		end
		if (state_q == S_ONE_WR) begin
			ent_q <= wr_data;
			if (mode_q == MODE_SET_PRIO) begin
				oldp_q <= dyn_prio(rd_data.sprio, rd_data.nice);
				yield_q <= {1'b0, npri_q[6:0]} < {1'b0, dyn_prio(rd_data.sprio, rd_data.nice)};
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.payload.status = status_q;
	assign out_ch.payload.chosen_slot = chosen_q;
	assign out_ch.payload.prev_prio = oldp_q;
	assign out_ch.payload.should_yield = yield_q;
endmodule
